[src/tblr_pkg.sv]
// Shared types and constants for the tile background line renderer.
package tblr_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_START  = 2'd1,
    CMD_RENDER = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_BG_MODE    = 3'd0;
  localparam logic [2:0] REG_FORMAT     = 3'd1;
  localparam logic [2:0] REG_GEOMETRY   = 3'd2;
  localparam logic [2:0] REG_MAP_BASE   = 3'd3;
  localparam logic [2:0] REG_TILE_BASE  = 3'd4;
  localparam logic [2:0] REG_SCROLL     = 3'd5;
  localparam logic [2:0] REG_PRIORITIES = 3'd6;
  localparam logic [2:0] REG_MOSAIC     = 3'd7;

  localparam logic [15:0] OPT_VFLAG = 16'h8000;

  // Queued word between front and back.
  typedef struct packed {
    logic [1:0]  command;
    logic [14:0] mem_address;
    logic [15:0] mem_data;
    logic [8:0]  line_number;
    logic        odd_field;
    logic        interlaced;
    logic [3:0]  mosaic_line_offset;
    logic [15:0] opt_horizontal;
    logic [15:0] opt_vertical;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_MAP   = 3'd1,
    ST_WAITM = 3'd2,
    ST_PLANE = 3'd3,
    ST_WAITP = 3'd4,
    ST_PIX   = 3'd5,
    ST_FLUSH = 3'd6
  } state_t;

endpackage

[src/tblr_front.sv]
// Front end: two-entry queue of input words.
module tblr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tblr_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_ready,
  output tblr_pkg::item_t q_item
);
  import tblr_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem_r[wp_r] <= in_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
    end
  end
endmodule

[src/tblr_back.sv]
// Back end: video memory, tile fetch sequencer and pixel emitter.
module tblr_back #(
  parameter int LAYER = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  tblr_pkg::item_t q_item,
  input  logic            cfg_valid,
  input  logic [2:0]      cfg_index,
  input  logic [19:0]     cfg_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [8:0]      out_pixel_x,
  output logic [7:0]      out_pixel_priority,
  output logic [7:0]      out_palette_address,
  output logic [2:0]      out_palette_number,
  output logic [7:0]      out_color_index,
  output logic            out_last
);
  import tblr_pkg::*;

  localparam logic [15:0] OPT_VALID = 16'h2000 << LAYER;
  localparam logic [7:0]  PAL_BASE0 = 8'(LAYER * 32);

  // Configuration registers
  logic [2:0]  bg_mode_r, geometry_r;
  logic [1:0]  format_r;
  logic [14:0] map_base_r, tile_base_r;
  logic [19:0] scroll_r;
  logic [15:0] prio_r;
  logic [5:0]  mosaic_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_mode_r <= '0; format_r <= '0; geometry_r <= '0; map_base_r <= '0;
      tile_base_r <= '0; scroll_r <= '0; prio_r <= '0; mosaic_r <= 6'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BG_MODE:    bg_mode_r   <= cfg_data[2:0];
        REG_FORMAT:     format_r    <= cfg_data[1:0];
        REG_GEOMETRY:   geometry_r  <= cfg_data[2:0];
        REG_MAP_BASE:   map_base_r  <= cfg_data[14:0];
        REG_TILE_BASE:  tile_base_r <= cfg_data[14:0];
        REG_SCROLL:     scroll_r    <= cfg_data;
        REG_PRIORITIES: prio_r      <= cfg_data[15:0];
        REG_MOSAIC:     mosaic_r    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic [1:0] mode;
  logic       hires, opt_on, mos_on, tsz, wide, tall, th4, tw4;
  logic [9:0] hscr;
  assign mode   = (format_r == 2'd3) ? 2'd2 : format_r;
  assign hires  = (bg_mode_r == 3'd5) || (bg_mode_r == 3'd6);
  assign opt_on = (bg_mode_r == 3'd2) || (bg_mode_r == 3'd4) || (bg_mode_r == 3'd6);
  assign mos_on = mosaic_r[5];
  assign tsz = geometry_r[2]; assign wide = geometry_r[0]; assign tall = geometry_r[1];
  assign th4 = tsz; assign tw4 = hires | tsz;
  assign hscr = hires ? {scroll_r[8:0], 1'b0} : scroll_r[9:0];

  // Line state
  state_t      st_r, st_nxt;
  logic signed [11:0] xpos_r;
  logic [9:0]  eline_r;
  logic [5:0]  mcd_r;
  logic [7:0]  hcol_r, hpri_r, hpal_r;
  logic [2:0]  hpn_r;
  item_t       cur_r;

  // Video memory, one write port and one read port
  logic [15:0] vram [32768];
  logic [14:0] raddr;
  logic [15:0] rdata_r;
  logic        do_write;
  always_ff @(posedge clk) begin
    if (do_write) vram[q_item.mem_address] <= q_item.mem_data;
    rdata_r <= vram[raddr];
  end

  // Column setup, combinational from current item and state
  logic [10:0] width;
  logic [10:0] x_u, col, hoff, hoffm;
  logic [9:0]  voff, voffm;
  logic [5:0]  tx, ty;
  logic [14:0] off;
  assign width = hires ? 11'd512 : 11'd256;
  assign x_u = xpos_r[10:0];
  assign col = x_u + {8'd0, hscr[2:0]};
  always_comb begin
    hoff = x_u + {1'b0, hscr};
    voff = eline_r + scroll_r[19:10];
    if (opt_on && (col >= 11'd8)) begin
      if (bg_mode_r == 3'd4) begin
        if ((cur_r.opt_horizontal & OPT_VALID) != '0) begin
          if ((cur_r.opt_horizontal & OPT_VFLAG) == '0)
            hoff = col + {cur_r.opt_horizontal[10:3], 3'd0};
          else voff = eline_r + cur_r.opt_horizontal[9:0];
        end
      end else begin
        if ((cur_r.opt_horizontal & OPT_VALID) != '0)
          hoff = col + {cur_r.opt_horizontal[10:3], 3'd0};
        if ((cur_r.opt_vertical & OPT_VALID) != '0)
          voff = eline_r + cur_r.opt_vertical[9:0];
      end
    end
  end
  // Masks: width<<tsz<<wide - 1, and width<<tsz<<tall - 1 for the vertical mask
  always_comb begin
    logic [3:0] hs, vs;
    hs = 4'd8 + {3'd0, hires} + {3'd0, tsz} + {3'd0, wide};
    vs = 4'd8 + {3'd0, hires} + {3'd0, tsz} + {3'd0, tall};
    hoffm = (hs >= 4'd11) ? hoff : (hoff & ((11'd1 << hs) - 11'd1));
    voffm = (vs >= 4'd10) ? voff : (voff & 10'((11'd1 << vs) - 11'd1));
  end
  assign tx = tw4 ? hoffm[9:4] : hoffm[8:3];
  assign ty = th4 ? voffm[9:4] : voffm[8:3];
  always_comb begin
    off = {5'd0, ty[4:0], tx[4:0]};
    if (tx[5] && wide) off = off + 15'd1024;
    if (ty[5] && tall) off = off + (wide ? 15'd2048 : 15'd1024);
  end

  // Latched column values
  logic [10:0] hoff_r;
  logic [9:0]  voff_r;
  logic [15:0] entry_r;
  logic [14:0] paddr_r;
  logic [1:0]  pidx_r;
  logic [63:0] data_r;
  logic [2:0]  pix_r;

  logic        fx, fy;
  logic [9:0]  tile0;
  logic [11:0] tile1;
  logic [14:0] paddr;
  assign fy = entry_r[15];
  assign fx = entry_r[14];
  always_comb begin
    tile0 = entry_r[9:0];
    if (tw4 && (hoff_r[3] ^ fx)) tile0 = tile0 + 10'd1;
    if (th4 && (voff_r[3] ^ fy)) tile0 = tile0 + 10'd16;
    tile1 = {2'd0, tile0} + 12'(tile_base_r >> (3 + mode));
    tile1 = tile1 & (12'hfff >> mode);
    paddr = 15'({3'd0, tile1} << (3 + mode)) + {12'd0, voff_r[2:0] ^ {3{fy}}};
  end

  // Pixel decode
  logic signed [11:0] px;
  logic [2:0] shift;
  logic [7:0] colr;
  logic [5:0] mcd_dec, msz;
  logic [4:0] sz;
  logic [7:0] pri, palb, pali;
  logic       inrange, take, emit, lastpix;
  assign px = xpos_r;
  assign inrange = (px >= 0) && (px < $signed({1'b0, width}));
  assign shift = fx ? pix_r : 3'd7 - pix_r;
  always_comb begin
    for (int k = 0; k < 8; k++) colr[k] = data_r[{k[2:0], 3'b000} + {3'd0, shift}];
    case (mode)
      2'd0: colr[7:2] = '0;
      2'd1: colr[7:4] = '0;
      default: ;
    endcase
  end
  assign mcd_dec = mcd_r - 6'd1;
  assign take = inrange && (mcd_dec == 6'd0);
  assign sz = (mosaic_r[4:0] == 5'd0) ? 5'd1 : mosaic_r[4:0];
  assign msz = mos_on ? (hires ? {sz, 1'b0} : {1'b0, sz}) : 6'd1;
  assign pri = entry_r[13] ? prio_r[15:8] : prio_r[7:0];
  assign palb = (bg_mode_r == 3'd0) ? PAL_BASE0 : 8'd0;
  assign pali = palb + 8'({5'd0, entry_r[12:10]} << (4'd2 << mode));
  logic [7:0] ncol;
  assign ncol = take ? colr : hcol_r;
  assign emit = inrange && (ncol != 8'd0);
  assign lastpix = (pix_r == 3'd7);

  // Pending result held back by one pixel so last can be marked
  logic have_pend_r;
  logic [8:0] px_p; logic [7:0] ppri_p, ppal_p, pcol_p; logic [2:0] ppn_p;

  // Current pixel word
  logic [8:0] cx; logic [7:0] cpri, cpal; logic [2:0] cpn;
  assign cx = px[8:0];
  assign cpri = take ? pri : hpri_r;
  assign cpal = take ? pali + colr : hpal_r;
  assign cpn = take ? entry_r[12:10] : hpn_r;

  // Output register: one registered result word
  logic ov_r;
  logic [8:0] ox_r; logic [7:0] opri_r, opal_r, ocol_r; logic [2:0] opn_r; logic olast_r;
  logic can_out, pix_go, flush_go, ld_out, sel_pend, ld_last;
  assign can_out = !ov_r || out_ready;
  assign pix_go = (st_r == ST_PIX) && can_out;
  assign flush_go = (st_r == ST_FLUSH) && can_out;
  assign ld_out = flush_go ||
                  (pix_go && ((emit && have_pend_r) || (lastpix && (emit || have_pend_r))));
  assign sel_pend = flush_go || have_pend_r;
  assign ld_last = flush_go || !have_pend_r || (lastpix && !emit);
  assign out_valid = ov_r;
  assign out_pixel_x = ox_r; assign out_pixel_priority = opri_r;
  assign out_palette_address = opal_r; assign out_palette_number = opn_r;
  assign out_color_index = ocol_r; assign out_last = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (ld_out) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      if (sel_pend) begin
        ox_r <= px_p; opri_r <= ppri_p; opal_r <= ppal_p; opn_r <= ppn_p; ocol_r <= pcol_p;
      end else begin
        ox_r <= cx; opri_r <= cpri; opal_r <= cpal; opn_r <= cpn; ocol_r <= ncol;
      end
      olast_r <= ld_last;
    end
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (q_valid && q_item.command == CMD_RENDER) st_nxt = ST_MAP;
      ST_MAP:   st_nxt = (xpos_r >= $signed({1'b0, width})) ? ST_IDLE : ST_WAITM;
      ST_WAITM: st_nxt = ST_PLANE;
      ST_PLANE: st_nxt = ST_WAITP;
      ST_WAITP: st_nxt = (pidx_r == 2'd3) ? ST_PIX : ST_PLANE;
      ST_PIX:   if (can_out && lastpix) st_nxt = (emit && have_pend_r) ? ST_FLUSH : ST_IDLE;
      ST_FLUSH: if (can_out) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_ready  = (st_r == ST_IDLE);
    do_write = (st_r == ST_IDLE) && q_valid && (q_item.command == CMD_WRITE);
    raddr    = (st_r == ST_MAP) ? map_base_r + off
             : ((st_r == ST_PLANE) && (pidx_r == 2'd0)) ? paddr
             : paddr_r + {8'd0, pidx_r, 3'd0};
  end

  logic [9:0] sy;
  always_comb begin
    sy = {1'b0, q_item.line_number};
    if (hires && q_item.interlaced)
      sy = {q_item.line_number, q_item.odd_field & ~mos_on};
    if (mos_on)
      sy = sy - ({6'd0, q_item.mosaic_line_offset} << (hires & q_item.interlaced));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; xpos_r <= '0; eline_r <= '0; mcd_r <= 6'd1;
      hcol_r <= '0; hpri_r <= '0; hpal_r <= '0; hpn_r <= '0;
      have_pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: if (q_valid) begin
          cur_r <= q_item;
          if (q_item.command == CMD_START) begin
            eline_r <= sy;
            xpos_r <= -$signed({9'd0, hscr[2:0]});
            mcd_r <= 6'd1;
            hcol_r <= '0; hpri_r <= '0; hpal_r <= '0; hpn_r <= '0;
          end
        end
        ST_MAP: begin
          hoff_r <= hoffm; voff_r <= voffm; pidx_r <= 2'd0;
          pix_r <= 3'd0; have_pend_r <= 1'b0;
        end
        ST_WAITM: entry_r <= rdata_r;
        ST_PLANE: if (pidx_r == 2'd0) paddr_r <= paddr;
        ST_WAITP: begin
          data_r[{pidx_r, 4'd0} +: 16] <= rdata_r;
          pidx_r <= pidx_r + 2'd1;
        end
        ST_PIX: if (can_out) begin
          if (inrange) mcd_r <= take ? msz : mcd_dec;
          if (take) begin
            hcol_r <= colr; hpri_r <= pri; hpal_r <= pali + colr; hpn_r <= entry_r[12:10];
          end
          // new word goes to pending unless it leaves now as the final one
          if (lastpix && !(emit && have_pend_r)) have_pend_r <= 1'b0;
          else if (emit) begin
            px_p <= cx; ppri_p <= cpri; ppal_p <= cpal; ppn_p <= cpn; pcol_p <= ncol;
            have_pend_r <= 1'b1;
          end
          xpos_r <= xpos_r + 12'sd1;
          pix_r <= pix_r + 3'd1;
        end
        // final pixel left both a pending and a new word: the new one goes out here
        ST_FLUSH: if (can_out) have_pend_r <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule

[src/tile_background_line_renderer_unit.sv]
// Top level of the tile background line renderer.
// Usage: input words carry a command (video memory write, start line, render
// one tile column) and their fields; handshake on in_valid/in_ready. Results
// come out on out_valid/out_ready, one word per opaque pixel, left to right,
// with out_last on the final word of a column. Registers are written on the
// cfg channel (cfg_index, cfg_data) by the user only while the unit is idle;
// the block does not enforce it; cfg is always ready. Writes and start-line
// words are done in the idle state. A render word is accepted, then a map
// read and its wait, four bitplane reads with a wait each through the single
// video memory read port, the eight pixels and a flush step if the last slot
// is opaque with a word pending; a finished line's word ends at the map step.
// A two-word queue in front lets input words arrive while the back end works.
// Reset (rst_n low, synchronous) clears registers, queue and line state; the
// video memory is undefined until written. When the receiver stalls, the
// pixel emitter holds and the queue fills, then in_ready drops.
module tile_background_line_renderer_unit #(
  parameter int LAYER = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [14:0] in_mem_address,
  input  logic [15:0] in_mem_data,
  input  logic [8:0]  in_line_number,
  input  logic        in_odd_field,
  input  logic        in_interlaced,
  input  logic [3:0]  in_mosaic_line_offset,
  input  logic [15:0] in_opt_horizontal,
  input  logic [15:0] in_opt_vertical,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  out_pixel_x,
  output logic [7:0]  out_pixel_priority,
  output logic [7:0]  out_palette_address,
  output logic [2:0]  out_palette_number,
  output logic [7:0]  out_color_index,
  output logic        out_last
);
  import tblr_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_ready;

  assign cfg_ready = 1'b1;
  assign in_item = '{command: in_command, mem_address: in_mem_address,
                     mem_data: in_mem_data, line_number: in_line_number,
                     odd_field: in_odd_field, interlaced: in_interlaced,
                     mosaic_line_offset: in_mosaic_line_offset,
                     opt_horizontal: in_opt_horizontal, opt_vertical: in_opt_vertical};

  tblr_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  tblr_back #(.LAYER(LAYER)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .cfg_valid, .cfg_index, .cfg_data,
    .out_valid, .out_ready, .out_pixel_x, .out_pixel_priority,
    .out_palette_address, .out_palette_number, .out_color_index, .out_last
  );
endmodule
